@@ design/ltrd_pkg.sv @@
// Package for the length-tagged record deque.
// Holds sizes, operation and status codes, item types and the padding function.
// No dependencies.
package ltrd_pkg;

  localparam int WORD_W           = 64;
  localparam int BYTES_W          = 10;
  localparam int COUNT_W          = 10;
  localparam int FUNC_W           = 3;
  localparam int STATUS_W         = 2;
  localparam int BUFFER_WORDS     = 1024;
  localparam int ADDR_W           = $clog2(BUFFER_WORDS);
  localparam int USED_W           = ADDR_W + 1;
  localparam int MAX_RECORD_WORDS = 64;
  localparam int WORD_BYTES       = 8;
  localparam int BYTE_SHIFT       = $clog2(WORD_BYTES);
  localparam int MAX_BYTES        = MAX_RECORD_WORDS * WORD_BYTES;
  localparam int REC_W            = $clog2(MAX_RECORD_WORDS + 1);
  localparam int PAD_W            = BYTES_W - BYTE_SHIFT + 1;
  localparam int NEED_W           = ((USED_W > PAD_W) ? USED_W : PAD_W) + 1;
  localparam int FRAME_WORDS      = 2;
  localparam int COUNT_LIMIT      = 1023;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH       = 3'd0,
    FUNC_GET_FRONT  = 3'd1,
    FUNC_GET_BACK   = 3'd2,
    FUNC_POP_FRONT  = 3'd3,
    FUNC_POP_BACK   = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_HDR  = 7'b0000010,
    ST_TRL  = 7'b0000100,
    ST_LOOK = 7'b0001000,
    ST_GET  = 7'b0010000,
    ST_POP  = 7'b0100000,
    ST_RES  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic               use_rd;
    logic [BYTES_W-1:0] byte_count;
    logic               run_end;
    status_t            status;
    logic [COUNT_W-1:0] record_count;
  } res_t;

  typedef struct packed {
    logic [WORD_W-1:0]  read_word;
    logic [BYTES_W-1:0] byte_count;
    logic               run_end;
    status_t            status;
    logic [COUNT_W-1:0] record_count;
  } out_item_t;

  function automatic logic [PAD_W-1:0] pad_words(input logic [BYTES_W-1:0] bytes);
    logic [BYTES_W:0] sum;
    sum = {1'b0, bytes} + (BYTES_W + 1)'(WORD_BYTES - 1);
    return PAD_W'(sum >> BYTE_SHIFT);
  endfunction

endpackage

@@ design/ltrd_outq.sv @@
// Two-entry result queue that decouples the deque control from the result channel.
// Depends on ltrd_pkg for the result word type.
module ltrd_outq import ltrd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  out_item_t wr_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  output logic [1:0] count
);

  out_item_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_item  = slot_r[rd_ptr_r];
  assign count     = cnt_r;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_en ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(wr_en) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

@@ design/length_tagged_record_deque_top.sv @@
// Push: each word is written from the idle state; a final push then writes the header in ST_HDR and
// the trailer in ST_TRL, once the result queue has room. Get: the header is read and decoded, then
// one stored word per cycle, while the result queue has room, from the single-port-read word store.
// Pop: after the header read, ST_POP frees the record; empty and dropped results go through ST_RES.
// Synchronous active-low reset clears pointers, counts and the push state; the word store
// is not cleared.
module length_tagged_record_deque_top import ltrd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [WORD_W-1:0]  in_payload_word,
  input  logic [BYTES_W-1:0] in_record_bytes,
  input  logic               in_push_final,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [WORD_W-1:0]  out_read_word,
  output logic [BYTES_W-1:0] out_byte_count,
  output logic               out_run_end,
  output logic [STATUS_W-1:0] out_status,
  output logic [COUNT_W-1:0] out_record_count
);

  logic [WORD_W-1:0] word_store_r [BUFFER_WORDS];
  logic [WORD_W-1:0] rd_word_r;

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  front_r, front_nxt;
  logic [ADDR_W-1:0]  back_r, back_nxt;
  logic [USED_W-1:0]  used_r, used_nxt;
  logic [COUNT_W-1:0] recs_r, recs_nxt;
  logic               push_act_r, push_act_nxt;
  logic               push_rej_r, push_rej_nxt;
  logic [BYTES_W-1:0] push_bytes_r, push_bytes_nxt;
  logic [REC_W-1:0]   push_done_r, push_done_nxt;
  logic [FUNC_W-1:0]  func_r, func_nxt;
  logic [BYTES_W-1:0] rec_bytes_r, rec_bytes_nxt;
  logic [REC_W-1:0]   rec_words_r, rec_words_nxt;
  logic [ADDR_W-1:0]  cur_r, cur_nxt;
  logic [REC_W-1:0]   cnt_r, cnt_nxt;
  res_t               res_r, res_nxt;
  logic               p1_vld_r, p1_vld_nxt;
  res_t               p1_r, p1_nxt;

  logic               we, re;
  logic [ADDR_W-1:0]  wa, ra;
  logic [WORD_W-1:0]  wd;

  logic               accept, first, fits, rej_new, eff_rej, cred_ok, q_pop, last, front_side;
  logic [BYTES_W-1:0] eff_bytes, hdr_bytes;
  logic [REC_W-1:0]   eff_done, eff_n, push_n, hdr_n;
  logic [NEED_W-1:0]  need;
  logic [USED_W-1:0]  rec_span;
  logic [1:0]         q_count, occ;
  out_item_t          q_wr_item, q_item;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign q_pop    = out_valid && out_ready;
  assign occ      = q_count + 2'(p1_vld_r);
  assign cred_ok  = (occ != 2'd2) || q_pop;

  assign first    = !push_act_r;
  assign need     = NEED_W'(FRAME_WORDS) + NEED_W'(pad_words(in_record_bytes));
  assign fits     = (NEED_W'(used_r) + need) <= NEED_W'(BUFFER_WORDS);
  assign rej_new  = (in_record_bytes > BYTES_W'(MAX_BYTES)) || !fits ||
                    (recs_r >= COUNT_W'(COUNT_LIMIT));
  assign eff_rej   = first ? rej_new : push_rej_r;
  assign eff_bytes = first ? in_record_bytes : push_bytes_r;
  assign eff_done  = first ? '0 : push_done_r;
  assign eff_n     = REC_W'(pad_words(eff_bytes));
  assign push_n    = REC_W'(pad_words(push_bytes_r));

  assign hdr_bytes  = (rd_word_r[BYTES_W-1:0] > BYTES_W'(MAX_BYTES)) ?
                      BYTES_W'(MAX_BYTES) : rd_word_r[BYTES_W-1:0];
  assign hdr_n      = REC_W'(pad_words(hdr_bytes));
  assign front_side = (func_r == FUNC_GET_FRONT) || (func_r == FUNC_POP_FRONT);
  assign last       = (cnt_r == rec_words_r - REC_W'(1));
  assign rec_span   = USED_W'(rec_words_r) + USED_W'(FRAME_WORDS);

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    used_nxt       = used_r;
    recs_nxt       = recs_r;
    push_act_nxt   = push_act_r;
    push_rej_nxt   = push_rej_r;
    push_bytes_nxt = push_bytes_r;
    push_done_nxt  = push_done_r;
    func_nxt       = func_r;
    rec_bytes_nxt  = rec_bytes_r;
    rec_words_nxt  = rec_words_r;
    cur_nxt        = cur_r;
    cnt_nxt        = cnt_r;
    res_nxt        = res_r;
    p1_vld_nxt     = 1'b0;
    p1_nxt         = p1_r;
    we             = 1'b0;
    wa             = back_r;
    wd             = {{(WORD_W - BYTES_W){1'b0}}, push_bytes_r};
    re             = 1'b0;
    ra             = cur_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_PUSH) begin
            push_act_nxt = 1'b1;
            if (first) begin
              push_rej_nxt   = rej_new;
              push_bytes_nxt = in_record_bytes;
              push_done_nxt  = '0;
            end
            if (!eff_rej && (eff_done < eff_n)) begin
              we            = 1'b1;
              wa            = back_r + ADDR_W'(1) + ADDR_W'(eff_done);
              wd            = in_payload_word;
              push_done_nxt = eff_done + REC_W'(1);
            end
            if (in_push_final) begin
              push_act_nxt = 1'b0;
              push_rej_nxt = 1'b0;
              if (eff_rej) begin
                res_nxt   = '{use_rd: 1'b0, byte_count: in_record_bytes, run_end: 1'b1,
                              status: STATUS_FULL, record_count: recs_r};
                state_nxt = ST_RES;
              end else begin
                state_nxt = ST_HDR;
              end
            end
          end else if ((in_func == FUNC_GET_FRONT) || (in_func == FUNC_GET_BACK) ||
                       (in_func == FUNC_POP_FRONT) || (in_func == FUNC_POP_BACK)) begin
            push_act_nxt = 1'b0;
            push_rej_nxt = 1'b0;
            func_nxt     = in_func;
            if (push_act_r && !push_rej_r) begin
              we = 1'b1;
              wa = back_r;
            end
            if (recs_r == '0) begin
              res_nxt   = '{use_rd: 1'b0, byte_count: '0, run_end: 1'b1,
                            status: STATUS_EMPTY, record_count: recs_r};
              state_nxt = ST_RES;
            end else begin
              re        = 1'b1;
              ra        = ((in_func == FUNC_GET_FRONT) || (in_func == FUNC_POP_FRONT)) ?
                          front_r : back_r - ADDR_W'(1);
              state_nxt = ST_LOOK;
            end
          end
        end
      end
      ST_HDR: begin
        we        = 1'b1;
        wa        = back_r;
        state_nxt = ST_TRL;
      end
      ST_TRL: begin
        if (cred_ok) begin
          we         = 1'b1;
          wa         = back_r + ADDR_W'(1) + ADDR_W'(push_n);
          back_nxt   = back_r + ADDR_W'(push_n) + ADDR_W'(FRAME_WORDS);
          used_nxt   = used_r + USED_W'(push_n) + USED_W'(FRAME_WORDS);
          recs_nxt   = recs_r + COUNT_W'(1);
          p1_vld_nxt = 1'b1;
          p1_nxt     = '{use_rd: 1'b0, byte_count: push_bytes_r, run_end: 1'b1,
                         status: STATUS_OK, record_count: recs_r + COUNT_W'(1)};
          state_nxt  = ST_IDLE;
        end
      end
      ST_LOOK: begin
        rec_bytes_nxt = hdr_bytes;
        rec_words_nxt = hdr_n;
        cnt_nxt       = '0;
        cur_nxt       = front_side ? front_r + ADDR_W'(1) :
                        back_r - ADDR_W'(1) - ADDR_W'(hdr_n);
        if ((func_r == FUNC_POP_FRONT) || (func_r == FUNC_POP_BACK)) begin
          state_nxt = ST_POP;
        end else if (hdr_n == '0) begin
          res_nxt   = '{use_rd: 1'b0, byte_count: '0, run_end: 1'b1,
                        status: STATUS_OK, record_count: recs_r};
          state_nxt = ST_RES;
        end else begin
          state_nxt = ST_GET;
        end
      end
      ST_GET: begin
        if (cred_ok) begin
          re         = 1'b1;
          ra         = cur_r;
          p1_vld_nxt = 1'b1;
          p1_nxt     = '{use_rd: 1'b1, byte_count: rec_bytes_r, run_end: last,
                         status: STATUS_OK, record_count: recs_r};
          cur_nxt    = cur_r + ADDR_W'(1);
          cnt_nxt    = cnt_r + REC_W'(1);
          if (last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_POP: begin
        if (cred_ok) begin
          if (front_side) begin
            front_nxt = front_r + ADDR_W'(rec_words_r) + ADDR_W'(FRAME_WORDS);
          end else begin
            back_nxt = back_r - ADDR_W'(rec_words_r) - ADDR_W'(FRAME_WORDS);
          end
          used_nxt   = (used_r >= rec_span) ? used_r - rec_span : '0;
          recs_nxt   = recs_r - COUNT_W'(1);
          p1_vld_nxt = 1'b1;
          p1_nxt     = '{use_rd: 1'b0, byte_count: rec_bytes_r, run_end: 1'b1,
                         status: STATUS_OK, record_count: recs_r - COUNT_W'(1)};
          state_nxt  = ST_IDLE;
        end
      end
      ST_RES: begin
        if (cred_ok) begin
          p1_vld_nxt = 1'b1;
          p1_nxt     = res_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= '0;
      back_r      <= '0;
      used_r      <= '0;
      recs_r      <= '0;
      push_act_r  <= 1'b0;
      push_rej_r  <= 1'b0;
      push_done_r <= '0;
      p1_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      used_r      <= used_nxt;
      recs_r      <= recs_nxt;
      push_act_r  <= push_act_nxt;
      push_rej_r  <= push_rej_nxt;
      push_done_r <= push_done_nxt;
      p1_vld_r    <= p1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    push_bytes_r <= push_bytes_nxt;
    func_r       <= func_nxt;
    rec_bytes_r  <= rec_bytes_nxt;
    rec_words_r  <= rec_words_nxt;
    cur_r        <= cur_nxt;
    cnt_r        <= cnt_nxt;
    res_r        <= res_nxt;
    p1_r         <= p1_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      word_store_r[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_word_r <= word_store_r[ra];
    end
  end

  assign q_wr_item = '{read_word: p1_r.use_rd ? rd_word_r : '0,
                       byte_count: p1_r.byte_count, run_end: p1_r.run_end,
                       status: p1_r.status, record_count: p1_r.record_count};

  ltrd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (p1_vld_r),
    .wr_item   (q_wr_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (q_item),
    .count     (q_count)
  );

  assign out_read_word    = q_item.read_word;
  assign out_byte_count   = q_item.byte_count;
  assign out_run_end      = q_item.run_end;
  assign out_status       = q_item.status;
  assign out_record_count = q_item.record_count;

endmodule

@@ design/ltrd_chk.sv @@
// Port-level checker for the length-tagged record deque, bound to the top level.
// Depends on ltrd_pkg for the port widths and the status codes.
module ltrd_chk import ltrd_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [FUNC_W-1:0]  in_func,
  input logic [WORD_W-1:0]  in_payload_word,
  input logic [BYTES_W-1:0] in_record_bytes,
  input logic               in_push_final,
  input logic               out_valid,
  input logic               out_ready,
  input logic [WORD_W-1:0]  out_read_word,
  input logic [BYTES_W-1:0] out_byte_count,
  input logic               out_run_end,
  input logic [STATUS_W-1:0] out_status,
  input logic [COUNT_W-1:0] out_record_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_word) &&
    $stable(out_byte_count) && $stable(out_run_end) && $stable(out_status) &&
    $stable(out_record_count))
    else $error("Stalled result word changed.");

  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_EMPTY) |->
    (out_byte_count == '0) && out_run_end && (out_record_count == '0) &&
    (out_read_word == '0))
    else $error("Empty result word is malformed.");

  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_FULL) |-> out_run_end && (out_read_word == '0))
    else $error("Dropped-record result word is malformed.");

  a_run_body: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_end |-> (out_status == STATUS_OK) && (out_byte_count != '0))
    else $error("Mid-run word is not an ok get word.");

endmodule

bind length_tagged_record_deque_top ltrd_chk u_ltrd_chk (.*);
